// ----- hw/rtl/lzsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the lzss token decompressor: byte and
// length widths, and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  // byte width of the compressed and decompressed streams
  localparam int unsigned BYTE_W = 8;

  // match length register: code 0..15 plus a minimum match of at most 16
  localparam int unsigned LEN_W = 5;

  // field positions inside the second token byte
  localparam int unsigned CODE_W = 4;

  // controller to datapath commands
  typedef struct packed {
    logic lit_write;    // store and emit the literal on the input
    logic tok_hi_load;  // latch first token byte
    logic tok_lo_load;  // latch second token byte, length and quotient
    logic rem_step;     // reduce offset modulo the window depth
    logic addr_step;    // form the copy source position
    logic read_issue;   // first window read of a match
    logic copy_step;    // emit and write back one copied byte
  } lzsd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_zero;    // input byte is zero
    logic out_free;   // output register can take a byte this cycle
    logic last_copy;  // the byte being copied ends the match
  } lzsd_sts_t;

endpackage

// ----- hw/rtl/lzsd_datapath.sv -----
// ----------------------------------------------------------------------------
// lzsd_datapath
// History window memory, write and source pointers, offset reduction and
// the output register of the lzss token decompressor.
// ----------------------------------------------------------------------------
module lzsd_datapath #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned MIN_MATCH    = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lzsd_pkg::lzsd_cmd_t       cmd,
  output lzsd_pkg::lzsd_sts_t       sts,
  input  logic [lzsd_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lzsd_pkg::BYTE_W-1:0] m_tdata,  // [7:0] out_byte
  output logic                      m_tlast     // last_of_run
);

  import lzsd_pkg::*;

  localparam int unsigned AW          = $clog2(WINDOW_DEPTH);
  localparam int unsigned OFS_W       = 12;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned PROD_W      = OFS_W + RECIP_W;
  localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;
  localparam int unsigned MD_W        = QUO_W + AW + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
  localparam logic [AW:0]   DEPTH_V  = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);

  // window storage and read side
  logic [BYTE_W-1:0] window [WINDOW_DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic              fwd_q;
  logic [BYTE_W-1:0] fwd_data_q;
  logic              valid_q;

  // pointers and token state
  logic [AW-1:0]     wp;
  logic              wrapped;
  logic [AW-1:0]     src;
  logic [BYTE_W-1:0] tok_hi;
  logic [OFS_W-1:0]  offset_q;
  logic [QUO_W-1:0]  quo;
  logic [AW-1:0]     rem;
  logic [LEN_W-1:0]  count;

  // output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  // combinational helpers
  logic [OFS_W-1:0]  offset_in;
  logic [PROD_W-1:0] prod;
  logic [MD_W-1:0]   quo_depth;
  logic [MD_W-1:0]   rem_full;
  logic [AW:0]       src_sum;
  logic [AW:0]       src_red;
  logic [AW-1:0]     src_next;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     src_inc;
  logic [BYTE_W-1:0] copy_byte;
  logic              we;
  logic [BYTE_W-1:0] wdata;
  logic              rd_en;
  logic              out_load;
  logic              last_copy;

  // offset from both token bytes, quotient by reciprocal multiply
  assign offset_in = {tok_hi, s_tdata[BYTE_W-1:CODE_W]};
  assign prod      = {RECIP_W'(0), offset_in} * {OFS_W'(0), RECIP};

  // remainder from registered quotient
  assign quo_depth = {(AW + 1)'(0), quo} * {QUO_W'(0), DEPTH_V};
  assign rem_full  = {(MD_W - OFS_W)'(0), offset_q} - quo_depth;

  // source position, wrapped once
  assign src_sum  = {1'b0, wp} + {1'b0, rem};
  assign src_red  = src_sum - DEPTH_V;
  assign src_next = (src_sum >= DEPTH_V) ? src_red[AW-1:0] : src_sum[AW-1:0];

  // circular pointer steps
  assign wp_inc  = (wp == LAST_POS) ? '0 : wp + AW'(1);
  assign src_inc = (src == LAST_POS) ? '0 : src + AW'(1);

  // copied byte: bypass, stored value, or zero for a never written entry
  assign copy_byte = fwd_q ? fwd_data_q : (valid_q ? mem_q : '0);

  assign last_copy = (count == LEN_W'(1));

  // write port and read enable
  assign we       = cmd.lit_write || cmd.copy_step;
  assign wdata    = cmd.lit_write ? s_tdata : copy_byte;
  assign rd_en    = cmd.read_issue || (cmd.copy_step && !last_copy);
  assign out_load = we;

  // status to controller
  assign sts.in_zero   = (s_tdata == '0);
  assign sts.out_free  = !out_valid || m_tready;
  assign sts.last_copy = last_copy;

  // window write
  always_ff @(posedge clk) begin
    if (we) begin
      window[wp] <= wdata;
    end
  end

  // window read, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= window[src];
    end
  end

  // bypass and fill tracking for the read in flight
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_q      <= we && (wp == src);
      fwd_data_q <= wdata;
      valid_q    <= wrapped || (src < wp);
    end
  end

  // write pointer and wrap mark
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (we) begin
      wp <= wp_inc;
      if (wp == LAST_POS) begin
        wrapped <= 1'b1;
      end
    end
  end

  // token fields, offset reduction and match length
  always_ff @(posedge clk) begin
    if (cmd.tok_hi_load) begin
      tok_hi <= s_tdata;
    end
    if (cmd.tok_lo_load) begin
      offset_q <= offset_in;
      quo      <= prod[PROD_W-1 -: QUO_W];
      count    <= LEN_W'(s_tdata[CODE_W-1:0]) + LEN_W'(MIN_MATCH);
    end else if (cmd.copy_step) begin
      count <= count - LEN_W'(1);
    end
    if (cmd.rem_step) begin
      rem <= rem_full[AW-1:0];
    end
  end

  // source pointer
  always_ff @(posedge clk) begin
    if (cmd.addr_step) begin
      src <= src_next;
    end else if (rd_en) begin
      src <= src_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= wdata;
      out_last <= cmd.lit_write || last_copy;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

// ----- hw/rtl/lzsd_controller.sv -----
// ----------------------------------------------------------------------------
// lzsd_controller
// Parse and copy sequencer: walks flag, literal and token bytes, then steps
// the datapath through offset reduction and the byte copy loop.
// ----------------------------------------------------------------------------
module lzsd_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lzsd_pkg::lzsd_sts_t sts,
  output lzsd_pkg::lzsd_cmd_t cmd
);

  import lzsd_pkg::*;

  typedef enum logic [3:0] {
    S_FLAG,
    S_LIT,
    S_THI,
    S_TLO,
    S_REM,
    S_ADDR,
    S_READ,
    S_COPY
  } state_t;

  state_t state;

  // commands and input ready per state
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_FLAG: begin
        s_tready = 1'b1;
      end
      S_LIT: begin
        s_tready      = sts.out_free;
        cmd.lit_write = s_tvalid && sts.out_free;
      end
      S_THI: begin
        s_tready        = 1'b1;
        cmd.tok_hi_load = s_tvalid;
      end
      S_TLO: begin
        s_tready        = 1'b1;
        cmd.tok_lo_load = s_tvalid;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
      end
      S_ADDR: begin
        cmd.addr_step = 1'b1;
      end
      S_READ: begin
        cmd.read_issue = 1'b1;
      end
      S_COPY: begin
        cmd.copy_step = sts.out_free;
      end
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FLAG;
    end else begin
      unique case (state)
        S_FLAG: begin
          if (s_tvalid) begin
            state <= sts.in_zero ? S_LIT : S_THI;
          end
        end
        S_LIT: begin
          if (cmd.lit_write) begin
            state <= S_FLAG;
          end
        end
        S_THI: begin
          if (s_tvalid) begin
            state <= S_TLO;
          end
        end
        S_TLO: begin
          if (s_tvalid) begin
            state <= S_REM;
          end
        end
        S_REM:  state <= S_ADDR;
        S_ADDR: state <= S_READ;
        S_READ: state <= S_COPY;
        S_COPY: begin
          if (cmd.copy_step && sts.last_copy) begin
            state <= S_FLAG;
          end
        end
        default: state <= S_FLAG;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lzss_token_decompressor.sv -----
// ----------------------------------------------------------------------------
// lzss_token_decompressor
// Byte-serial lzss decoder: flag, literal and two-byte match tokens in,
// decompressed bytes out, with a circular history window.
// ----------------------------------------------------------------------------
// flag and first token byte: no output
// literal: once the output register has room, byte appears in it the next cycle
// match of L bytes: token low byte, offset reduction, source address and first
//   window read, then one byte per cycle while the output register has room,
//   each with a window write and, but for the last, a window read; reset clears
//   the write pointer and parse state; unwritten window entries read as zero
// ----------------------------------------------------------------------------
module lzss_token_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned MIN_MATCH    = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lzsd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lzsd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
  output logic                        m_tlast    // last_of_run
);

  import lzsd_pkg::*;

  lzsd_cmd_t cmd;
  lzsd_sts_t sts;

  // parse and copy sequencer
  lzsd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window, pointers and output register
  lzsd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MIN_MATCH    (MIN_MATCH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a copied byte is only produced when the output register has room
  assert property (@(posedge clk) disable iff (rst)
    cmd.copy_step |-> sts.out_free)
    else $error("copy step while output register is blocked");

  // no input transaction while a match is being copied
  assert property (@(posedge clk) disable iff (rst)
    cmd.copy_step |-> !s_tready)
    else $error("input accepted during match copy");

  // the final copied byte returns the parser to the flag phase
  assert property (@(posedge clk) disable iff (rst)
    cmd.copy_step && sts.last_copy |=> s_tready)
    else $error("parser not back at flag phase after match");

  // a literal shows up as a complete run of one byte
  assert property (@(posedge clk) disable iff (rst)
    cmd.lit_write |=> m_tvalid && m_tlast)
    else $error("literal not presented as last byte of its run");

endmodule

// ----- tb/lzss_token_decompressor_tb.sv -----
// ----------------------------------------------------------------------------
// lzss_token_decompressor_tb
// Self-checking bench for the lzss token decoder. A stream of flag, literal
// and match token bytes goes in through the slave port. A behavioral decoder
// with its own history window predicts every output byte and its tlast flag,
// and each output transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module lzss_token_decompressor_tb;

  import lzsd_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned MIN_MATCH    = 3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned STREAM_ITEMS = 208;
  localparam int unsigned MAX_REPORTS  = 40;

  // decoder parse position within the compressed stream
  typedef enum logic [1:0] {
    AWAIT_FLAG,
    AWAIT_LITERAL,
    AWAIT_OFFSET_HI,
    AWAIT_OFFSET_LO
  } parse_phase_t;

  // one entry of the send queue: a stream byte, or a hold until drained
  typedef struct packed {
    logic              hold;
    logic [BYTE_W-1:0] data;
  } stream_item_t;

  // one predicted output transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;   // [7:0] in_byte
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;        // [7:0] out_byte
  logic              m_tlast;        // last_of_run

  stream_item_t stream_q[$];
  out_byte_t    expected_bytes[$];

  // behavioral decoder state
  logic [BYTE_W-1:0] history [WINDOW_DEPTH];
  int unsigned       wr_pos;
  parse_phase_t      phase;
  logic [BYTE_W-1:0] offset_hi;

  int unsigned error_count    = 0;
  int unsigned literal_count  = 0;
  int unsigned match_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned planned_items  = 0;
  bit          in_taken       = 1'b0;

  always #1 clk = ~clk;

  lzss_token_decompressor #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MIN_MATCH    (MIN_MATCH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // behavioral decoder
  // ---------------------------------------------------------------------------

  task automatic store_and_expect(input logic [BYTE_W-1:0] b, input logic last);
    out_byte_t ob;
    history[wr_pos] = b;
    wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
    ob.data = b;
    ob.last = last;
    expected_bytes.push_back(ob);
  endtask

  task automatic decode_stream_byte(input logic [BYTE_W-1:0] b);
    int unsigned offset;
    int unsigned length;
    int unsigned src;
    case (phase)
      AWAIT_FLAG: begin
        phase = (b == 8'h00) ? AWAIT_LITERAL : AWAIT_OFFSET_HI;
      end
      AWAIT_LITERAL: begin
        store_and_expect(b, 1'b1);
        literal_count++;
        phase = AWAIT_FLAG;
      end
      AWAIT_OFFSET_HI: begin
        offset_hi = b;
        phase = AWAIT_OFFSET_LO;
      end
      default: begin
        offset = {offset_hi, b[7:4]};
        length = b[3:0] + MIN_MATCH;
        src    = (wr_pos + offset) % WINDOW_DEPTH;
        // copy one byte at a time so overlapping copies see their own output
        for (int unsigned i = 0; i < length; i++) begin
          store_and_expect(history[(src + i) % WINDOW_DEPTH], i + 1 == length);
        end
        match_count++;
        phase = AWAIT_FLAG;
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_raw(input logic [BYTE_W-1:0] b);
    stream_item_t it;
    it.hold = 1'b0;
    it.data = b;
    stream_q.push_back(it);
    planned_items++;
  endtask

  task automatic push_hold();
    stream_item_t it;
    it.hold = 1'b1;
    it.data = '0;
    stream_q.push_back(it);
  endtask

  task automatic push_literal(input logic [BYTE_W-1:0] b);
    push_raw(8'h00);
    push_raw(b);
  endtask

  // flag must be nonzero; offset is 12 bits, code 4 bits
  task automatic push_match(input logic [BYTE_W-1:0] flag, input logic [11:0] offset,
                            input logic [3:0] code);
    push_raw(flag);
    push_raw(offset[11:4]);
    push_raw({offset[3:0], code});
  endtask

  function automatic logic [BYTE_W-1:0] random_flag();
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [11:0] random_offset();
    case ($urandom_range(0, 5))
      0:       return 12'hFFF;                               // run of last byte
      1:       return 12'hFF0 | 12'($urandom_range(0, 15));  // short overlap
      2:       return 12'h000;                               // oldest entry
      3:       return 12'hF00 | 12'($urandom_range(0, 255)); // recent history
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] random_code();
    case ($urandom_range(0, 3))
      0:       return 4'h0;
      1:       return 4'hF;
      default: return 4'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    wr_pos    = 0;
    phase     = AWAIT_FLAG;
    offset_hi = '0;
    foreach (history[i]) history[i] = '0;

    // directed: byte extremes, zero and max offset, overlap, far source
    push_literal(8'h00);
    push_literal(8'hFF);
    push_match(8'h01, 12'h000, 4'h0);
    push_match(8'hFF, 12'hFFF, 4'hF);
    push_match(8'h80, 12'hFFC, 4'h7);
    push_literal(8'hA5);
    push_literal(8'h5A);
    push_match(8'h7F, 12'h800, 4'hF);
    push_literal(8'h3C);
    push_hold();

    // random mix with some noise bytes, up to the stream budget
    while (planned_items < STREAM_ITEMS) begin
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_literal(BYTE_W'($urandom));
      end else if (pick < 88) begin
        push_match(random_flag(), random_offset(), random_code());
      end else begin
        push_raw(BYTE_W'($urandom));
      end
      if (planned_items inside {[70:72], [140:142]} && $urandom_range(0, 1) == 0) begin
        push_hold();
      end
    end
    push_hold();

    // stream cut short inside a match token: nothing should come out
    push_raw(8'h05);
    push_raw(8'h12);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (stream_q.size() != 0 || s_tvalid || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    // longest match is MIN_MATCH + 15 bytes plus startup; catch stray outputs
    repeat (4 * (MIN_MATCH + 20)) @(posedge clk);

    $display("Sent %0d stream bytes: %0d literals and %0d matches decoded,",
             bytes_sent, literal_count, match_count);
    $display("%0d output bytes checked, with overlapping and never written sources",
             bytes_checked);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of stream bytes with random gaps, holds until drained
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    logic              next_valid;
    logic [BYTE_W-1:0] next_data;
    stream_item_t      it;
    next_valid = s_tvalid;
    next_data  = s_tdata;
    if (!rst && (!s_tvalid || in_taken)) begin
      next_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (stream_q.size() != 0) begin
        if (stream_q[0].hold) begin
          // wait for every predicted byte before moving on
          if (expected_bytes.size() == 0) begin
            it = stream_q.pop_front();
          end
        end else begin
          it = stream_q.pop_front();
          next_valid = 1'b1;
          next_data  = it.data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_taken = 1'b0;
    s_tvalid <= next_valid;
    s_tdata  <= next_data;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern switching between modes
  // ---------------------------------------------------------------------------

  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  always @(negedge clk) begin
    logic ready;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      0:       ready = 1'b1;
      1:       ready = ($urandom_range(0, 3) != 0);
      2:       ready = ($urandom_range(0, 2) == 0);
      default: ready = ((rx_left % 8) < 5);
    endcase
    m_tready <= rst ? 1'b0 : ready;
  end

  // ---------------------------------------------------------------------------
  // monitor: check output transactions, then predict from input transactions
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_byte_t ob;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                    m_tdata, m_tlast));
        end else begin
          ob = expected_bytes.pop_front();
          if (m_tdata !== ob.data) begin
            report_mismatch($sformatf("out_byte %02h, predicted %02h", m_tdata, ob.data));
          end
          if (m_tlast !== ob.last) begin
            report_mismatch($sformatf("last_of_run %0b, predicted %0b", m_tlast, ob.last));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        bytes_sent++;
        decode_stream_byte(s_tdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles with no transaction on either side
  // ---------------------------------------------------------------------------

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR @%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
